// File: rtl/core/gpio_fsl_pkg.sv
package gpio_fsl_pkg;

    // Pin count and derived sizes
    localparam int PIN_COUNT       = 54;
    localparam int PINS_PER_SELECT = 10;
    localparam int FIELD_W         = 3;
    localparam int SEL_DATA_W      = PINS_PER_SELECT * FIELD_W;
    localparam int SEL_PINS        = (PIN_COUNT < 60) ? PIN_COUNT : 60;
    localparam int SEL_WORDS       = (SEL_PINS + PINS_PER_SELECT - 1) / PINS_PER_SELECT;
    localparam int SEL_IDX_W       = (SEL_WORDS > 1) ? $clog2(SEL_WORDS) : 1;
    localparam int BUS_W           = 32;
    localparam int WORD_IDX_W      = 4;

    // Function code that marks a pin as output
    localparam logic [FIELD_W-1:0] OUTPUT_CODE = 3'd1;

    // Register word indexes
    localparam logic [WORD_IDX_W-1:0] SET_LO = 4'd7;
    localparam logic [WORD_IDX_W-1:0] SET_HI = 4'd8;
    localparam logic [WORD_IDX_W-1:0] CLR_LO = 4'd10;
    localparam logic [WORD_IDX_W-1:0] CLR_HI = 4'd11;
    localparam logic [WORD_IDX_W-1:0] LVL_LO = 4'd13;
    localparam logic [WORD_IDX_W-1:0] LVL_HI = 4'd14;

    // Bus access kinds
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef logic [SEL_DATA_W-1:0] sel_word_t;

    // Bits of a select word that belong to existing pins
    function automatic sel_word_t sel_word_mask(input int w);
        sel_word_t m;
        m = '0;
        for (int k = 0; k < PINS_PER_SELECT; k++)
        begin
            if (w * PINS_PER_SELECT + k < SEL_PINS)
            begin
                m[k*FIELD_W +: FIELD_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/core/gpio_function_select_set_clear_level.sv
// GPIO register block: function select, set/clear latch and level read words.
// The result of an accepted transaction is registered and reaches the output in the next cycle.
// Throughput: one transaction per cycle; the input stalls only while a result
// is held by a stalled output register.
// Reset: asynchronous, active low; clears every pin function to input, the
// output latch, and the output valid flag.
module gpio_function_select_set_clear_level
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [gpio_fsl_pkg::WORD_IDX_W-1:0]   word_index,
    input  logic [gpio_fsl_pkg::BUS_W-1:0]        write_data,
    input  logic [gpio_fsl_pkg::PIN_COUNT-1:0]    pin_levels,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [gpio_fsl_pkg::BUS_W-1:0]        read_data,
    output logic [gpio_fsl_pkg::PIN_COUNT-1:0]    out_latch,
    output logic [gpio_fsl_pkg::PIN_COUNT-1:0]    out_enable
);

    localparam int PC = gpio_fsl_pkg::PIN_COUNT;
    localparam int BW = gpio_fsl_pkg::BUS_W;

    gpio_fsl_pkg::sel_word_t [gpio_fsl_pkg::SEL_WORDS-1:0] sel_reg, sel_next;
    logic [PC-1:0] latch_reg, latch_next;
    logic [PC-1:0] enable_reg, enable_next;
    logic [BW-1:0] read_data_reg, read_data_next;
    logic          out_valid_reg;

    logic                                accept;
    logic                                sel_hit;
    logic [gpio_fsl_pkg::SEL_IDX_W-1:0]  sel_idx;
    logic [2*BW-1:0]                     data_wide;
    logic [2*BW-1:0]                     data_hi_wide;
    logic [2*BW-1:0]                     level_wide;
    logic [PC-1:0]                       shifted_lo;
    logic [PC-1:0]                       shifted_hi;
    logic [PC-1:0]                       level_word;

    // Hold the input while a result waits on a stalled output
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign sel_hit = (word_index < gpio_fsl_pkg::WORD_IDX_W'(gpio_fsl_pkg::SEL_WORDS));
    assign sel_idx = word_index[gpio_fsl_pkg::SEL_IDX_W-1:0];

    // Place the bus word at the low or high half of the pin vector
    assign data_wide    = {{BW{1'b0}}, write_data};
    assign data_hi_wide = {write_data, {BW{1'b0}}};
    assign shifted_lo   = data_wide[PC-1:0];
    assign shifted_hi   = data_hi_wide[PC-1:0];

    // Level view: latch for output pins, external level otherwise
    assign level_word = (latch_reg & enable_reg) | (pin_levels & ~enable_reg);
    assign level_wide = (2*BW)'(level_word);

    // Decode the access and compute next state and read data
    always_comb
    begin
        sel_next       = sel_reg;
        latch_next     = latch_reg;
        read_data_next = '0;
        if (sel_hit)
        begin
            if (action == gpio_fsl_pkg::ACT_WRITE)
            begin
                sel_next[sel_idx] = write_data[gpio_fsl_pkg::SEL_DATA_W-1:0]
                                    & gpio_fsl_pkg::sel_word_mask(int'(sel_idx));
            end
            else
            begin
                read_data_next = BW'(sel_reg[sel_idx]);
            end
        end
        else
        begin
            unique case (word_index) inside
                gpio_fsl_pkg::SET_LO:
                begin
                    if (action == gpio_fsl_pkg::ACT_WRITE)
                        latch_next = latch_reg | shifted_lo;
                end
                gpio_fsl_pkg::SET_HI:
                begin
                    if (action == gpio_fsl_pkg::ACT_WRITE)
                        latch_next = latch_reg | shifted_hi;
                end
                gpio_fsl_pkg::CLR_LO:
                begin
                    if (action == gpio_fsl_pkg::ACT_WRITE)
                        latch_next = latch_reg & ~shifted_lo;
                end
                gpio_fsl_pkg::CLR_HI:
                begin
                    if (action == gpio_fsl_pkg::ACT_WRITE)
                        latch_next = latch_reg & ~shifted_hi;
                end
                gpio_fsl_pkg::LVL_LO:
                begin
                    if (action == gpio_fsl_pkg::ACT_READ)
                        read_data_next = level_wide[BW-1:0];
                end
                gpio_fsl_pkg::LVL_HI:
                begin
                    if (action == gpio_fsl_pkg::ACT_READ)
                        read_data_next = level_wide[2*BW-1:BW];
                end
                default:
                begin
                    read_data_next = '0;
                end
            endcase
        end
    end

    // Derive the output enable of each pin from its next function code
    always_comb
    begin
        enable_next = '0;
        for (int p = 0; p < gpio_fsl_pkg::SEL_PINS; p++)
        begin
            enable_next[p] = (sel_next[p / gpio_fsl_pkg::PINS_PER_SELECT]
                              [(p % gpio_fsl_pkg::PINS_PER_SELECT) * gpio_fsl_pkg::FIELD_W
                               +: gpio_fsl_pkg::FIELD_W] == gpio_fsl_pkg::OUTPUT_CODE);
        end
    end

    // Advance state and the result register on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= '0;
            latch_reg     <= '0;
            enable_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sel_reg    <= sel_next;
                latch_reg  <= latch_next;
                enable_reg <= enable_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold read data with its transaction
    always_ff @(posedge clk)
    begin
        if (accept)
            read_data_reg <= read_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign out_latch  = latch_reg;
    assign out_enable = enable_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_latch_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(latch_reg) && $stable(enable_reg))
        else $error("pin state changed without a transaction");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(read_data_reg) && $stable(latch_reg))
        else $error("stalled result changed");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int PIN_COUNT       = gpio_fsl_pkg::PIN_COUNT;
    localparam int BUS_W           = gpio_fsl_pkg::BUS_W;
    localparam int FIELD_W         = gpio_fsl_pkg::FIELD_W;
    localparam int WORD_IDX_W      = gpio_fsl_pkg::WORD_IDX_W;
    localparam int SEL_WORDS       = gpio_fsl_pkg::SEL_WORDS;
    localparam int PINS_PER_SELECT = gpio_fsl_pkg::PINS_PER_SELECT;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_PRINTED    = 40;
    localparam int INDEX_COUNT    = 2 ** WORD_IDX_W;

    typedef struct packed {
        logic [BUS_W-1:0]     rdata;
        logic [PIN_COUNT-1:0] latch;
        logic [PIN_COUNT-1:0] enable;
    } gpio_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   action;
    logic [WORD_IDX_W-1:0]  word_index;
    logic [BUS_W-1:0]       write_data;
    logic [PIN_COUNT-1:0]   pin_levels;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BUS_W-1:0]       read_data;
    logic [PIN_COUNT-1:0]   out_latch;
    logic [PIN_COUNT-1:0]   out_enable;

    // Shadow copy of the pin functions and the output latch
    logic [FIELD_W-1:0]     pin_func [PIN_COUNT] = '{default: '0};
    logic [PIN_COUNT-1:0]   latch_model = '0;

    gpio_result_t           pending_results [$];
    int                     sent_count     = 0;
    int                     checked_count  = 0;
    int                     mismatch_count = 0;
    int                     idle_cycles    = 0;
    int                     send_idle_pct  = 0;
    int                     recv_idle_pct  = 0;
    int                     stall_left     = 0;

    gpio_function_select_set_clear_level i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .word_index (word_index),
        .write_data (write_data),
        .pin_levels (pin_levels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .out_latch  (out_latch),
        .out_enable (out_enable)
    );

    always #6 clk = ~clk;

    // Per-pin output enable from the shadow function fields
    function automatic logic [PIN_COUNT-1:0] pin_enables();
        logic [PIN_COUNT-1:0] en;
        en = '0;
        for (int p = 0; p < PIN_COUNT; p++)
        begin
            en[p] = (pin_func[p] == gpio_fsl_pkg::OUTPUT_CODE);
        end
        return en;
    endfunction

    // Apply one bus access to the shadow state and return what the block drives
    function automatic gpio_result_t gpio_model_access(input logic act,
                                                       input logic [WORD_IDX_W-1:0] idx,
                                                       input logic [BUS_W-1:0] data,
                                                       input logic [PIN_COUNT-1:0] lev);
        gpio_result_t         res;
        logic [BUS_W-1:0]     rd;
        logic [2*BUS_W-1:0]   wide;
        logic [PIN_COUNT-1:0] en;
        int                   p;
        rd   = '0;
        wide = '0;
        if (idx < SEL_WORDS)
        begin
            for (int k = 0; k < PINS_PER_SELECT; k++)
            begin
                p = int'(idx) * PINS_PER_SELECT + k;
                if (p < PIN_COUNT)
                begin
                    if (act == gpio_fsl_pkg::ACT_WRITE)
                        pin_func[p] = data[k*FIELD_W +: FIELD_W];
                    else
                        rd[k*FIELD_W +: FIELD_W] = pin_func[p];
                end
            end
        end
        else if (idx == gpio_fsl_pkg::SET_LO || idx == gpio_fsl_pkg::SET_HI)
        begin
            if (act == gpio_fsl_pkg::ACT_WRITE)
            begin
                wide = (idx == gpio_fsl_pkg::SET_HI) ? {data, {BUS_W{1'b0}}}
                                                     : {{BUS_W{1'b0}}, data};
                latch_model = latch_model | wide[PIN_COUNT-1:0];
            end
        end
        else if (idx == gpio_fsl_pkg::CLR_LO || idx == gpio_fsl_pkg::CLR_HI)
        begin
            if (act == gpio_fsl_pkg::ACT_WRITE)
            begin
                wide = (idx == gpio_fsl_pkg::CLR_HI) ? {data, {BUS_W{1'b0}}}
                                                     : {{BUS_W{1'b0}}, data};
                latch_model = latch_model & ~wide[PIN_COUNT-1:0];
            end
        end
        else if (idx == gpio_fsl_pkg::LVL_LO || idx == gpio_fsl_pkg::LVL_HI)
        begin
            if (act == gpio_fsl_pkg::ACT_READ)
            begin
                en = pin_enables();
                wide[PIN_COUNT-1:0] = (latch_model & en) | (lev & ~en);
                rd = (idx == gpio_fsl_pkg::LVL_HI) ? wide[2*BUS_W-1:BUS_W]
                                                   : wide[BUS_W-1:0];
            end
        end
        res.rdata  = (act == gpio_fsl_pkg::ACT_WRITE) ? '0 : rd;
        res.latch  = latch_model;
        res.enable = pin_enables();
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch: %0s at result %0d: got %h, expected %h",
                     what, checked_count, got, want);
    endtask

    // Offer one transaction and hold it until the block takes it
    task automatic bus_access(input logic act, input logic [WORD_IDX_W-1:0] idx,
                              input logic [BUS_W-1:0] data, input logic [PIN_COUNT-1:0] lev);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid   = 1'b0;
            action     = 1'($urandom_range(1));
            word_index = WORD_IDX_W'($urandom_range(INDEX_COUNT - 1));
            write_data = $urandom;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = act;
        word_index = idx;
        write_data = data;
        pin_levels = lev;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Drive the output stall: long hold first, else random idling
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check accepted results, predict accepted transactions, watch for a hang
    always @(posedge clk)
    begin : monitor
        gpio_result_t want;
        logic         moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(read_data), '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (read_data !== want.rdata)
                        report_mismatch("read_data", 64'(read_data), 64'(want.rdata));
                    if (out_latch !== want.latch)
                        report_mismatch("out_latch", 64'(out_latch), 64'(want.latch));
                    if (out_enable !== want.enable)
                        report_mismatch("out_enable", 64'(out_enable), 64'(want.enable));
                end
                checked_count++;
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                pending_results.push_back(gpio_model_access(action, word_index,
                                                            write_data, pin_levels));
                sent_count++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Read every word index straight after reset
    task automatic test_register_map();
        logic [63:0] rnd;
        for (int w = 0; w < INDEX_COUNT; w++)
        begin
            rnd = {$urandom, $urandom};
            bus_access(gpio_fsl_pkg::ACT_READ, w[WORD_IDX_W-1:0], $urandom,
                       rnd[PIN_COUNT-1:0]);
        end
    endtask

    // Select words at their extremes, including the partial last word
    task automatic test_select_extremes();
        logic [BUS_W-1:0] all_out;
        all_out = '1;
        for (int k = 0; k < PINS_PER_SELECT; k++)
            all_out[k*FIELD_W +: FIELD_W] = gpio_fsl_pkg::OUTPUT_CODE;
        bus_access(gpio_fsl_pkg::ACT_WRITE, 4'(0), '1, '0);
        bus_access(gpio_fsl_pkg::ACT_READ, 4'(0), '1, '1);
        bus_access(gpio_fsl_pkg::ACT_WRITE, 4'(SEL_WORDS - 1), all_out, '0);
        bus_access(gpio_fsl_pkg::ACT_READ, 4'(SEL_WORDS - 1), '0, '0);
        bus_access(gpio_fsl_pkg::ACT_WRITE, 4'(SEL_WORDS / 2), all_out, '0);
    endtask

    // Set, clear and level words with all-ones and all-zeros data
    task automatic test_latch_extremes();
        bus_access(gpio_fsl_pkg::ACT_WRITE, gpio_fsl_pkg::SET_LO, '1, '0);
        bus_access(gpio_fsl_pkg::ACT_WRITE, gpio_fsl_pkg::SET_HI, '1, '0);
        bus_access(gpio_fsl_pkg::ACT_READ, gpio_fsl_pkg::LVL_LO, '0, '0);
        bus_access(gpio_fsl_pkg::ACT_READ, gpio_fsl_pkg::LVL_HI, '0, '1);
        bus_access(gpio_fsl_pkg::ACT_WRITE, gpio_fsl_pkg::LVL_LO, '1, '1);
        bus_access(gpio_fsl_pkg::ACT_WRITE, gpio_fsl_pkg::CLR_LO, '1, '1);
        bus_access(gpio_fsl_pkg::ACT_READ, gpio_fsl_pkg::LVL_LO, '0, '1);
        bus_access(gpio_fsl_pkg::ACT_WRITE, gpio_fsl_pkg::CLR_HI, '1, '0);
        bus_access(gpio_fsl_pkg::ACT_READ, gpio_fsl_pkg::LVL_HI, '1, '1);
    endtask

    // Mostly meaningful register traffic with a share of random noise
    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        logic                  act;
        logic [WORD_IDX_W-1:0] idx;
        logic [BUS_W-1:0]      data;
        logic [63:0]           rnd;
        int                    pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            data = $urandom;
            rnd  = {$urandom, $urandom};
            act  = gpio_fsl_pkg::ACT_READ;
            if (pick < 30)
            begin
                // select write, about half the fields turned to output
                act = gpio_fsl_pkg::ACT_WRITE;
                idx = WORD_IDX_W'($urandom_range(SEL_WORDS - 1));
                for (int k = 0; k < PINS_PER_SELECT; k++)
                    if ($urandom_range(1))
                        data[k*FIELD_W +: FIELD_W] = gpio_fsl_pkg::OUTPUT_CODE;
            end
            else if (pick < 45)
            begin
                act = gpio_fsl_pkg::ACT_WRITE;
                idx = $urandom_range(1) ? gpio_fsl_pkg::SET_HI : gpio_fsl_pkg::SET_LO;
            end
            else if (pick < 58)
            begin
                act  = gpio_fsl_pkg::ACT_WRITE;
                idx  = $urandom_range(1) ? gpio_fsl_pkg::CLR_HI : gpio_fsl_pkg::CLR_LO;
                data = data & $urandom;
            end
            else if (pick < 78)
            begin
                idx = $urandom_range(1) ? gpio_fsl_pkg::LVL_HI : gpio_fsl_pkg::LVL_LO;
            end
            else if (pick < 88)
            begin
                idx = WORD_IDX_W'($urandom_range(SEL_WORDS - 1));
            end
            else
            begin
                act = 1'($urandom_range(1));
                idx = WORD_IDX_W'($urandom_range(INDEX_COUNT - 1));
            end
            bus_access(act, idx, data, rnd[PIN_COUNT-1:0]);
        end
    endtask

    // Hold the output for a long stretch while traffic keeps coming
    task automatic test_output_hold();
        logic [63:0] rnd;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = LONG_HOLD;
        for (int i = 0; i < 40; i++)
        begin
            rnd = {$urandom, $urandom};
            bus_access(1'($urandom_range(1)), WORD_IDX_W'($urandom_range(INDEX_COUNT - 1)),
                       $urandom, rnd[PIN_COUNT-1:0]);
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = gpio_fsl_pkg::ACT_READ;
        word_index = '0;
        write_data = '0;
        pin_levels = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_register_map();
        test_select_extremes();
        test_latch_extremes();
        test_random_traffic(330, 20, 62);
        test_output_hold();
        test_random_traffic(330, 62, 20);
        wait_results_drained();
        test_random_traffic(340, 0, 0);

        // Let the last results out, then settle for the pipeline latency
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_results_drained();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 64'(pending_results.size()), '0);

        $display("covered %0d bus transactions, %0d results checked, %0d mismatches",
                 sent_count, checked_count, mismatch_count);
        $display("all word indexes, select/set/clear/level paths, idling and a long hold");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
